>>> rtl/core/nfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared types and fixed constants of the normalised fir convolver.
// ----------------------------------------------------------------------------
package nfc_pkg;

  localparam int COEF_W      = 16;
  localparam int QUO_W       = 62;  // 2^60 / energy, padded to an even width
  localparam int DIV_STEPS   = 61;
  localparam int ROOT_W      = 31;
  localparam int SQRT_STEPS  = 31;
  localparam int INV_W       = 32;
  localparam int INV_FRAC    = 30;
  localparam int SCALE_STEPS = 32;
  localparam int STEP_CW     = 6;

  typedef struct packed {
    logic capture;
    logic tap_step;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic norm_write;
    logic smp_write;
    logic mac_issue;
    logic scale_init;
    logic scale_step;
    logic load_out;
  } nfc_cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic ch_ok;
    logic filter_ok;
    logic mac_done;
    logic pipe_busy;
    logic out_free;
  } nfc_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/nfc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_ram
// Simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/nfc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_ctrl
// Sequencer: tap load, reciprocal norm, sample mac and scaling steps.
// ----------------------------------------------------------------------------
module nfc_ctrl
  import nfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire nfc_stat_t stat,
  output nfc_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_TAP    = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_NORM   = 4'd5;
  localparam logic [3:0] S_SMP    = 4'd6;
  localparam logic [3:0] S_MAC    = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_SCALE  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]         state, state_next;
  logic [STEP_CW-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.op) begin
          state_next = S_TAP;
        end else if (!stat.ch_ok) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SMP;
        end
      end
      S_TAP: begin
        cmd.tap_step = 1'b1;
        if (stat.last) begin
          cmd.div_init = 1'b1;
          cnt_next     = STEP_CW'(DIV_STEPS - 1);
          state_next   = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) begin
          cmd.sqrt_init = 1'b1;
          cnt_next      = STEP_CW'(SQRT_STEPS - 1);
          state_next    = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm_write = 1'b1;
        state_next     = S_IDLE;
      end
      S_SMP: begin
        cmd.smp_write = 1'b1;
        state_next    = stat.filter_ok ? S_MAC : S_OUT;
      end
      S_MAC: begin
        if (stat.mac_done) begin
          state_next = S_DRAIN;
        end else begin
          cmd.mac_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.scale_init = 1'b1;
          cnt_next       = STEP_CW'(SCALE_STEPS - 1);
          state_next     = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        cnt_next       = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/nfc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_datapath
// Tap and history stores, energy, divide, square root, mac and scaling.
// ----------------------------------------------------------------------------
module nfc_datapath
  import nfc_pkg::*;
#(
  parameter int MAX_TAPS    = 1024,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nfc_cmd_t                      cmd,
  output nfc_stat_t                          stat,
  input  wire logic                          op,
  input  wire logic signed [COEF_W-1:0]      coefficient,
  input  wire logic                          last_coefficient,
  input  wire logic                          channel,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_channel,
  output logic signed [SAMPLE_BITS-1:0]      filtered_sample,
  output logic                               status
);

  localparam int TW  = $clog2(MAX_TAPS + 1);
  localparam int PW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HD  = CHANNELS * MAX_TAPS;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int EW  = 2 * COEF_W - 2 + TW;
  localparam int PRW = COEF_W + SAMPLE_BITS;
  localparam int AW  = PRW + TW;
  localparam int SPW = AW + INV_W;
  localparam int QSW = SPW - INV_FRAC;
  localparam int RW  = ROOT_W + 2;
  localparam logic [QSW-1:0] POS_LIM = QSW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [QSW-1:0] NEG_LIM = QSW'(64'd1 << (SAMPLE_BITS - 1));

  // captured item
  logic                          op_q, last_q, ch_q;
  logic signed [COEF_W-1:0]      coef_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;

  logic [TW-1:0]    tap_count, load_index;
  logic [EW-1:0]    energy;
  logic [INV_W-1:0] inv_norm;
  logic [PW-1:0]    ptr  [CHANNELS];
  logic [TW-1:0]    fill [CHANNELS];

  logic [EW-1:0]    div_rem;
  logic             div_one;
  logic [QUO_W-1:0] quo;
  logic [RW-1:0]    sq_rem;
  logic [ROOT_W-1:0] root;

  logic [TW-1:0]  mac_i;
  logic [PW-1:0]  idx;
  logic           v1, g1, v2;
  logic signed [PRW-1:0] prod;
  logic signed [AW-1:0]  acc;

  logic [AW-1:0]    mag;
  logic             neg;
  logic [INV_W-1:0] inv_sh;
  logic [SPW-1:0]   sprod;

  logic [CIW-1:0]   ch_idx;
  logic             ch_ok, filter_ok, fail;
  logic signed [2*COEF_W-1:0] coef_sq;
  logic [EW-1:0]    e_base;
  logic             tap_room;
  logic [TW-1:0]    li_inc;
  logic [EW:0]      div_sh;
  logic             div_bit;
  logic [RW+1:0]    sq_sh, sq_trial;
  logic             sq_bit;
  logic [PW-1:0]    ptr_cur, ptr_inc, idx_dec;
  logic [TW-1:0]    fill_cur;
  logic [HAW-1:0]   hbase;
  logic             gate;
  logic signed [COEF_W-1:0]      tap_dout;
  logic signed [SAMPLE_BITS-1:0] hist_dout, hist_term;
  logic [QSW-1:0]   qv;
  logic [SAMPLE_BITS-1:0] sat;

  assign ch_idx    = CIW'(ch_q);
  assign ch_ok     = (int'(ch_q) < CHANNELS);
  assign filter_ok = (tap_count != '0) && (inv_norm != '0);
  assign fail      = !ch_ok || !filter_ok;

  assign coef_sq  = coef_q * coef_q;
  assign e_base   = (load_index == '0) ? '0 : energy;
  assign tap_room = (load_index < TW'(MAX_TAPS));
  assign li_inc   = load_index + 1'b1;

  assign div_sh  = {div_rem, div_one};
  assign div_bit = (div_sh >= {1'b0, energy});

  assign sq_sh    = {sq_rem, quo[QUO_W-1 -: 2]};
  assign sq_trial = (RW+2)'({root, 2'b01});
  assign sq_bit   = (sq_sh >= sq_trial);

  assign ptr_cur  = ptr[ch_idx];
  assign fill_cur = fill[ch_idx];
  assign ptr_inc  = (ptr_cur == PW'(MAX_TAPS - 1)) ? '0 : ptr_cur + 1'b1;
  assign idx_dec  = (idx == '0) ? PW'(MAX_TAPS - 1) : idx - 1'b1;
  assign hbase    = HAW'(ch_idx) * HAW'(MAX_TAPS);
  // history entries not written since the last clear read as zero
  assign gate     = (mac_i < fill_cur);
  assign hist_term = g1 ? hist_dout : '0;

  assign qv  = sprod[SPW-1:INV_FRAC];
  always_comb begin
    if (neg) begin
      sat = (qv > NEG_LIM) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : -qv[SAMPLE_BITS-1:0];
    end else begin
      sat = (qv > POS_LIM) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : qv[SAMPLE_BITS-1:0];
    end
  end

  assign stat.op        = op_q;
  assign stat.last      = last_q;
  assign stat.ch_ok     = ch_ok;
  assign stat.filter_ok = filter_ok;
  assign stat.mac_done  = (mac_i == tap_count);
  assign stat.pipe_busy = v1 | v2;
  assign stat.out_free  = !out_valid || out_ready;

  nfc_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk     (clk),
    .wr_en   (cmd.tap_step && tap_room),
    .wr_addr (load_index[PW-1:0]),
    .wr_data (coef_q),
    .rd_en   (cmd.mac_issue),
    .rd_addr (mac_i[PW-1:0]),
    .rd_data (tap_dout)
  );

  nfc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HD)) u_hist_ram (
    .clk     (clk),
    .wr_en   (cmd.smp_write),
    .wr_addr (hbase + HAW'(ptr_cur)),
    .wr_data (smp_q),
    .rd_en   (cmd.mac_issue),
    .rd_addr (hbase + HAW'(idx)),
    .rd_data (hist_dout)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= '0;
      load_index <= '0;
      energy     <= '0;
      inv_norm   <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr[c]  <= '0;
        fill[c] <= '0;
      end
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
      if (cmd.tap_step) begin
        if (load_index == '0) begin
          tap_count <= '0;
          inv_norm  <= '0;
        end
        energy <= tap_room ? e_base + EW'(coef_sq[2*COEF_W-2:0]) : e_base;
        if (tap_room) begin
          load_index <= li_inc;
        end
        if (last_q) begin
          tap_count  <= tap_room ? li_inc : load_index;
          load_index <= '0;
          for (int c = 0; c < CHANNELS; c++) begin
            ptr[c]  <= '0;
            fill[c] <= '0;
          end
        end
      end
      if (cmd.norm_write) begin
        inv_norm <= (energy == '0) ? '0 : INV_W'(root);
      end
      if (cmd.smp_write) begin
        ptr[ch_idx] <= ptr_inc;
        if (fill_cur != TW'(MAX_TAPS)) begin
          fill[ch_idx] <= fill_cur + 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      coef_q <= coefficient;
      last_q <= last_coefficient;
      ch_q   <= channel;
      smp_q  <= sample_value;
    end
    if (cmd.div_init) begin
      div_rem <= '0;
      div_one <= 1'b1;
      quo     <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_bit ? EW'(div_sh - {1'b0, energy}) : div_sh[EW-1:0];
      div_one <= 1'b0;
      quo     <= {quo[QUO_W-2:0], div_bit};
    end else if (cmd.sqrt_step) begin
      quo <= {quo[QUO_W-3:0], 2'b00};
    end
    if (cmd.sqrt_init) begin
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rem <= sq_bit ? RW'(sq_sh - sq_trial) : sq_sh[RW-1:0];
      root   <= {root[ROOT_W-2:0], sq_bit};
    end
    if (cmd.smp_write) begin
      mac_i <= '0;
      idx   <= ptr_cur;
      acc   <= '0;
    end else begin
      if (cmd.mac_issue) begin
        mac_i <= mac_i + 1'b1;
        idx   <= idx_dec;
      end
      if (v2) begin
        acc <= acc + AW'(prod);
      end
    end
    g1   <= gate;
    prod <= tap_dout * hist_term;
    if (cmd.scale_init) begin
      mag    <= acc[AW-1] ? AW'(-acc) : AW'(acc);
      neg    <= acc[AW-1];
      inv_sh <= inv_norm;
      sprod  <= '0;
    end else if (cmd.scale_step) begin
      sprod  <= {sprod[SPW-2:0], 1'b0} + (inv_sh[INV_W-1] ? SPW'(mag) : '0);
      inv_sh <= {inv_sh[INV_W-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      out_channel     <= ch_q;
      filtered_sample <= fail ? '0 : sat;
      status          <= fail;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/normalized_fir_convolver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_fir_convolver_core
// Unit-energy normalised fir filter over several audio channels.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): op 0 loads one tap, op 1 presents one
// sample. Output channel (out_valid/out_ready): one result per sample item.
// in_ready is high only while the sequencer is idle; one item at a time.
// The final tap item also runs a 61-step restoring divide of 2^60 by
// the energy and a 31-step square root.
// A sample item runs the single shared multiply-accumulate, walking
// every tap, then a 32-step serial scaling multiply; both are skipped
// when there is no usable filter.
// The result sits in an output register, so a new item is taken while it
// waits; if the receiver stalls, the next sample's work finishes and waits
// for that register to free before the block goes idle again.
// Reset clears the filter (status 1 results until a load ends) and the
// delay lines; a finished load empties the delay lines at once.
// ----------------------------------------------------------------------------
module normalized_fir_convolver_core
  import nfc_pkg::*;
#(
  parameter int MAX_TAPS    = 1024,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic signed [COEF_W-1:0]      coefficient,
  input  wire logic                          last_coefficient,
  input  wire logic                          channel,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_channel,
  output logic signed [SAMPLE_BITS-1:0]      filtered_sample,
  output logic                               status
);

  nfc_cmd_t  cmd;
  nfc_stat_t stat;

  nfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nfc_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .op               (op),
    .coefficient      (coefficient),
    .last_coefficient (last_coefficient),
    .channel          (channel),
    .sample_value     (sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .filtered_sample  (filtered_sample),
    .status           (status)
  );

endmodule
`default_nettype wire

>>> rtl/core/nfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_checker
// Port-level checks of the convolver core, bound to the top level.
// ----------------------------------------------------------------------------
module nfc_checker
  import nfc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          op,
  input wire logic signed [COEF_W-1:0]      coefficient,
  input wire logic                          last_coefficient,
  input wire logic                          channel,
  input wire logic signed [SAMPLE_BITS-1:0] sample_value,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_channel,
  input wire logic signed [SAMPLE_BITS-1:0] filtered_sample,
  input wire logic                          status
);

  // one item at a time: an accepted transfer makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an input transfer");

  a_error_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> filtered_sample == '0)
    else $error("error status with a non-zero sample");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_sample)
      && $stable(status) && $stable(out_channel))
    else $error("stalled result changed");

endmodule

bind normalized_fir_convolver_core nfc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_nfc_checker (.*);
`default_nettype wire
